/* hw/rtl/oal_pkg.sv */
// ----------------------------------------------------------------------------
// oal_pkg
// Shared types and constants of the ordered array list: operation and
// status codes, field widths and the control word sent along the cell chain.
// ----------------------------------------------------------------------------
package oal_pkg;

    localparam int unsigned MODE_W   = 2;
    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned POS_W    = 7;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned LEN_W    = 8;

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT = 2'd0,
        MODE_DELETE = 2'd1,
        MODE_FIND   = 2'd2,
        MODE_READ   = 2'd3
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_FULL      = 2'd1,
        STATUS_BAD_POS   = 2'd2,
        STATUS_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DELETE,
        CELL_ROTATE
    } cell_op_t;

    typedef struct packed {
        cell_op_t           op;
        logic [POS_W-1:0]   pos;
    } cell_ctrl_t;

endpackage

/* hw/rtl/oal_in_if.sv */
// ----------------------------------------------------------------------------
// oal_in_if
// Request channel of the ordered array list: one beat carries one operation.
// ----------------------------------------------------------------------------
interface oal_in_if;
    import oal_pkg::*;

    logic                       valid;
    logic                       ready;
    mode_t                      mode;
    logic signed [VALUE_W-1:0]  item_value;
    logic [POS_W-1:0]           position;

    modport source (output valid, mode, item_value, position, input ready);
    modport sink (input valid, mode, item_value, position, output ready);
endinterface

/* hw/rtl/oal_out_if.sv */
// ----------------------------------------------------------------------------
// oal_out_if
// Response channel of the ordered array list: one beat per operation.
// ----------------------------------------------------------------------------
interface oal_out_if;
    import oal_pkg::*;

    logic                       valid;
    logic                       ready;
    status_t                    status;
    logic [POS_W-1:0]           found_index;
    logic signed [VALUE_W-1:0]  read_value;
    logic [LEN_W-1:0]           list_length;

    modport source (output valid, status, found_index, read_value, list_length, input ready);
    modport sink (input valid, status, found_index, read_value, list_length, output ready);
endinterface

/* hw/rtl/ordered_array_list_core.sv */
// ----------------------------------------------------------------------------
// ordered_array_list_core
// Ordered list of signed words held in a chain of cells with a length count.
// ----------------------------------------------------------------------------
// Insert, delete and an out-of-range read finish in the cycle the request beat
// is taken, with the response registered for the next cycle. Find and an
// in-range read rotate the whole list once past cell 0, where a single
// comparator and capture register look at one entry per cycle, and the list
// is back in order when the response appears. A new request is taken while
// no rotation runs and the response register is empty or being emptied in
// the same cycle. Entries need no clearing after reset; only the length
// count is cleared.
// ----------------------------------------------------------------------------
module ordered_array_list_core #(
    parameter int unsigned CAPACITY      = 128,
    parameter int unsigned ELEMENT_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    oal_in_if.sink      req,
    oal_out_if.source   rsp
);
    import oal_pkg::*;

    localparam int unsigned CNT_W     = $clog2(CAPACITY + 1);
    localparam int unsigned STEP_W    = $clog2(CAPACITY);
    localparam int unsigned CMP_W     = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int unsigned LEN_EXT_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;
    localparam logic [CNT_W-1:0]  CAP_COUNT = CNT_W'(CAPACITY);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CAPACITY - 1);

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } state_t;

    state_t                     state_reg, state_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [STEP_W-1:0]          step_reg, step_next;
    mode_t                      mode_reg, mode_next;
    logic [ELEMENT_WIDTH-1:0]   key_reg, key_next;
    logic [CMP_W-1:0]           pos_reg, pos_next;
    logic                       hit_reg, hit_next;
    logic [STEP_W-1:0]          hit_index_reg, hit_index_next;
    logic [ELEMENT_WIDTH-1:0]   hit_data_reg, hit_data_next;

    logic                       out_valid_reg, out_valid_next;
    status_t                    out_status_reg, out_status_next;
    logic [POS_W-1:0]           out_found_reg, out_found_next;
    logic [VALUE_W-1:0]         out_value_reg, out_value_next;
    logic [LEN_W-1:0]           out_length_reg, out_length_next;

    logic                       in_fire;
    logic [ELEMENT_WIDTH-1:0]   in_elem;
    logic [CMP_W-1:0]           pos_ext;
    logic [CMP_W-1:0]           cnt_ext;
    logic [CMP_W-1:0]           step_ext;
    logic [CNT_W-1:0]           step_cnt;
    logic                       scan_match;
    logic [STEP_W-1:0]          found_src;
    logic [CMP_W-1:0]           found_ext;
    logic [ELEMENT_WIDTH-1:0]   read_src;
    logic [VALUE_W-1:0]         read_word;
    logic [LEN_EXT_W-1:0]       len_next_ext;
    logic [LEN_EXT_W-1:0]       len_cur_ext;
    logic [LEN_W-1:0]           len_cur;

    cell_ctrl_t                 cell_ctrl;
    logic [ELEMENT_WIDTH-1:0]   cell_data [CAPACITY];

    // ---- element conversion ----
    if (ELEMENT_WIDTH <= VALUE_W)
    begin : g_in_narrow
        assign in_elem = req.item_value[ELEMENT_WIDTH-1:0];
    end
    else
    begin : g_in_wide
        assign in_elem = {{(ELEMENT_WIDTH - VALUE_W){req.item_value[VALUE_W-1]}},
                          req.item_value};
    end

    if (ELEMENT_WIDTH >= VALUE_W)
    begin : g_rd_wide
        assign read_word = read_src[VALUE_W-1:0];
    end
    else
    begin : g_rd_narrow
        assign read_word = {{(VALUE_W - ELEMENT_WIDTH){read_src[ELEMENT_WIDTH-1]}}, read_src};
    end

    // ---- cell chain ----
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [ELEMENT_WIDTH-1:0] left_data;
        logic [ELEMENT_WIDTH-1:0] right_data;

        if (i == 0)
        begin : g_first
            assign left_data = in_elem;
        end
        else
        begin : g_inner_l
            assign left_data = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_data = cell_data[0];
        end
        else
        begin : g_inner_r
            assign right_data = cell_data[i+1];
        end

        oal_cell #(
            .INDEX         (i),
            .ELEMENT_WIDTH (ELEMENT_WIDTH)
        ) u_cell (
            .clk        (clk),
            .ctrl       (cell_ctrl),
            .new_value  (in_elem),
            .left_data  (left_data),
            .right_data (right_data),
            .data       (cell_data[i])
        );
    end

    // ---- handshake and compares ----
    assign req.ready = (state_reg == S_IDLE) && (!out_valid_reg || rsp.ready);
    assign in_fire   = req.valid && req.ready;

    assign pos_ext  = CMP_W'(req.position);
    assign cnt_ext  = CMP_W'(count_reg);
    assign step_ext = CMP_W'(step_reg);
    assign step_cnt = CNT_W'(step_reg);

    assign scan_match = !hit_reg && (step_cnt < count_reg) && (cell_data[0] == key_reg);
    assign found_src  = scan_match ? step_reg : hit_index_reg;
    assign found_ext  = CMP_W'(found_src);
    assign read_src   = (step_ext == pos_reg) ? cell_data[0] : hit_data_reg;

    // length register always tracks the count
    assign len_next_ext    = LEN_EXT_W'(count_next);
    assign out_length_next = len_next_ext[LEN_W-1:0];
    assign len_cur_ext     = LEN_EXT_W'(count_reg);
    assign len_cur         = len_cur_ext[LEN_W-1:0];

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        step_next       = step_reg;
        mode_next       = mode_reg;
        key_next        = key_reg;
        pos_next        = pos_reg;
        hit_next        = hit_reg;
        hit_index_next  = hit_index_reg;
        hit_data_next   = hit_data_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_found_next  = out_found_reg;
        out_value_next  = out_value_reg;
        cell_ctrl.op    = CELL_HOLD;
        cell_ctrl.pos   = req.position;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    mode_next      = req.mode;
                    key_next       = in_elem;
                    pos_next       = pos_ext;
                    hit_next       = 1'b0;
                    hit_index_next = '0;
                    hit_data_next  = in_elem;
                    step_next      = '0;
                    out_found_next = '0;
                    out_value_next = '0;

                    unique case (req.mode)
                        MODE_INSERT:
                        begin
                            out_valid_next = 1'b1;
                            if (count_reg == CAP_COUNT)
                            begin
                                out_status_next = STATUS_FULL;
                            end
                            else if (pos_ext > cnt_ext)
                            begin
                                out_status_next = STATUS_BAD_POS;
                            end
                            else
                            begin
                                out_status_next = STATUS_OK;
                                cell_ctrl.op    = CELL_INSERT;
                                count_next      = count_reg + 1'b1;
                            end
                        end
                        MODE_DELETE:
                        begin
                            out_valid_next = 1'b1;
                            if (pos_ext >= cnt_ext)
                            begin
                                out_status_next = STATUS_BAD_POS;
                            end
                            else
                            begin
                                out_status_next = STATUS_OK;
                                cell_ctrl.op    = CELL_DELETE;
                                count_next      = count_reg - 1'b1;
                            end
                        end
                        MODE_FIND:
                        begin
                            state_next = S_SCAN;
                        end
                        MODE_READ:
                        begin
                            if (pos_ext >= cnt_ext)
                            begin
                                out_valid_next  = 1'b1;
                                out_status_next = STATUS_BAD_POS;
                                out_value_next  = '1;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                // advance the list one place toward cell 0
                cell_ctrl.op = CELL_ROTATE;
                step_next    = step_reg + 1'b1;
                if (mode_reg == MODE_FIND)
                begin
                    if (scan_match)
                    begin
                        hit_next       = 1'b1;
                        hit_index_next = step_reg;
                    end
                end
                else
                begin
                    hit_data_next = read_src;
                end

                if (step_reg == LAST_STEP)
                begin
                    state_next     = S_IDLE;
                    step_next      = '0;
                    out_valid_next = 1'b1;
                    if (mode_reg == MODE_FIND)
                    begin
                        out_value_next = '0;
                        if (hit_reg || scan_match)
                        begin
                            out_status_next = STATUS_OK;
                            out_found_next  = found_ext[POS_W-1:0];
                        end
                        else
                        begin
                            out_status_next = STATUS_NOT_FOUND;
                            out_found_next  = '0;
                        end
                    end
                    else
                    begin
                        out_status_next = STATUS_OK;
                        out_found_next  = '0;
                        out_value_next  = read_word;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            step_reg       <= '0;
            mode_reg       <= MODE_INSERT;
            key_reg        <= '0;
            pos_reg        <= '0;
            hit_reg        <= 1'b0;
            hit_index_reg  <= '0;
            hit_data_reg   <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= STATUS_OK;
            out_found_reg  <= '0;
            out_value_reg  <= '0;
            out_length_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            step_reg       <= step_next;
            mode_reg       <= mode_next;
            key_reg        <= key_next;
            pos_reg        <= pos_next;
            hit_reg        <= hit_next;
            hit_index_reg  <= hit_index_next;
            hit_data_reg   <= hit_data_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_found_reg  <= out_found_next;
            out_value_reg  <= out_value_next;
            out_length_reg <= out_length_next;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.found_index = out_found_reg;
    assign rsp.read_value  = out_value_reg;
    assign rsp.list_length = out_length_reg;

    // ---- assertions ----
    a_full_insert_holds: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && (req.mode == MODE_INSERT) && (count_reg == CAP_COUNT)
        |=> (count_reg == CAP_COUNT) && (out_status_reg == STATUS_FULL))
        else $error("insert into full list changed the count");

    a_find_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && (req.mode == MODE_FIND) |=> (state_reg == S_SCAN) && !out_valid_reg)
        else $error("find did not start a rotation");

    a_length_tracks_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_length_reg == len_cur))
        else $error("response length differs from list count");

    a_scan_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) && (step_reg == LAST_STEP)
        |=> (state_reg == S_IDLE) && out_valid_reg)
        else $error("rotation did not end with a response");

endmodule

/* hw/rtl/oal_cell.sv */
// ----------------------------------------------------------------------------
// oal_cell
// One list entry. Holds, takes the new value, or takes a neighbor's entry
// depending on the chain command and its own place relative to the position.
// ----------------------------------------------------------------------------
module oal_cell #(
    parameter int unsigned INDEX         = 0,
    parameter int unsigned ELEMENT_WIDTH = 32
) (
    input  logic                        clk,
    input  oal_pkg::cell_ctrl_t         ctrl,
    input  logic [ELEMENT_WIDTH-1:0]    new_value,
    input  logic [ELEMENT_WIDTH-1:0]    left_data,
    input  logic [ELEMENT_WIDTH-1:0]    right_data,
    output logic [ELEMENT_WIDTH-1:0]    data
);
    import oal_pkg::*;

    localparam int unsigned IDX_W = $clog2(INDEX + 1) + 1;
    localparam int unsigned CMP_W = (IDX_W > POS_W) ? IDX_W : POS_W;
    localparam logic [CMP_W-1:0] MY_INDEX = CMP_W'(INDEX);

    logic [CMP_W-1:0]           pos_ext;
    logic                       at_pos;
    logic                       past_pos;
    logic [ELEMENT_WIDTH-1:0]   data_reg;
    logic [ELEMENT_WIDTH-1:0]   data_next;

    assign pos_ext  = CMP_W'(ctrl.pos);
    assign at_pos   = (MY_INDEX == pos_ext);
    assign past_pos = (MY_INDEX > pos_ext);

    always_comb
    begin
        data_next = data_reg;
        case (ctrl.op)
            CELL_INSERT:
            begin
                if (at_pos)
                begin
                    data_next = new_value;
                end
                else if (past_pos)
                begin
                    data_next = left_data;
                end
            end
            CELL_DELETE:
            begin
                if (at_pos || past_pos)
                begin
                    data_next = right_data;
                end
            end
            CELL_ROTATE:
            begin
                data_next = right_data;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

/* dv/oal_list_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// oal_list_checker
// Watches the request and response channels of the ordered array list,
// keeps its own copy of the list and its length, works out the response to
// every request beat and compares each response beat field by field with the
// oldest one still due. Mismatches and the number of responses still due are
// handed to the testbench top.
// ----------------------------------------------------------------------------
module oal_list_checker #(
    parameter int unsigned CAPACITY = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    oal_in_if           req,
    oal_out_if          rsp,
    output int          mismatches,
    output int          pending,
    output int          pred_len,
    output int          responses,
    output int          peak_len,
    output int          full_rejects,
    output int          find_misses
);
    import oal_pkg::*;

    localparam int MAX_SHOWN = 10;

    typedef struct packed {
        status_t                    status;
        logic [POS_W-1:0]           found_index;
        logic signed [VALUE_W-1:0]  read_value;
        logic [LEN_W-1:0]           list_length;
    } list_reply_t;

    list_reply_t                replies_due[$];
    logic signed [VALUE_W-1:0]  list_words [CAPACITY];
    int                         list_len;

    function automatic list_reply_t apply_request(mode_t op,
                                                  logic signed [VALUE_W-1:0] v,
                                                  logic [POS_W-1:0] p);
        list_reply_t r;
        int          idx;
        r             = '0;
        r.status      = STATUS_OK;
        case (op)
            MODE_INSERT:
            begin
                if (list_len >= CAPACITY)
                begin
                    r.status = STATUS_FULL;
                end
                else if (int'(p) > list_len)
                begin
                    r.status = STATUS_BAD_POS;
                end
                else
                begin
                    for (idx = list_len; idx > int'(p); idx--)
                        list_words[idx] = list_words[idx-1];
                    list_words[p] = v;
                    list_len++;
                end
            end
            MODE_DELETE:
            begin
                if (int'(p) >= list_len)
                begin
                    r.status = STATUS_BAD_POS;
                end
                else
                begin
                    for (idx = int'(p); idx + 1 < list_len; idx++)
                        list_words[idx] = list_words[idx+1];
                    list_len--;
                end
            end
            MODE_FIND:
            begin
                r.status = STATUS_NOT_FOUND;
                for (idx = 0; idx < list_len; idx++)
                begin
                    if (list_words[idx] == v)
                    begin
                        r.status      = STATUS_OK;
                        r.found_index = idx[POS_W-1:0];
                        break;
                    end
                end
            end
            default:
            begin
                if (int'(p) >= list_len)
                begin
                    r.status     = STATUS_BAD_POS;
                    r.read_value = '1;
                end
                else
                begin
                    r.read_value = list_words[p];
                end
            end
        endcase
        r.list_length = list_len[LEN_W-1:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        list_reply_t due;
        if (!rst_n)
        begin
            replies_due.delete();
            list_len     = 0;
            mismatches   = 0;
            pending      = 0;
            pred_len     = 0;
            responses    = 0;
            peak_len     = 0;
            full_rejects = 0;
            find_misses  = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                responses++;
                if (replies_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("%0t: response beat with none due:", $realtime,
                                 " status %0d idx %0d value %0d len %0d",
                                 rsp.status, rsp.found_index, rsp.read_value,
                                 rsp.list_length);
                end
                else
                begin
                    due = replies_due.pop_front();
                    if (rsp.status !== due.status || rsp.found_index !== due.found_index ||
                        rsp.read_value !== due.read_value ||
                        rsp.list_length !== due.list_length)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_SHOWN)
                            $display("%0t: mismatch: expected status %0d idx %0d",
                                     $realtime, due.status, due.found_index,
                                     " value %0d len %0d,", due.read_value,
                                     due.list_length,
                                     " got status %0d idx %0d value %0d len %0d",
                                     rsp.status, rsp.found_index, rsp.read_value,
                                     rsp.list_length);
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                due = apply_request(req.mode, req.item_value, req.position);
                replies_due.push_back(due);
                if (due.status == STATUS_FULL)
                    full_rejects++;
                if (due.status == STATUS_NOT_FOUND)
                    find_misses++;
                if (list_len > peak_len)
                    peak_len = list_len;
            end
            pending  = replies_due.size();
            pred_len = list_len;
        end
    end

endmodule

/* dv/tb_ordered_array_list_core.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ordered_array_list_core
// Testbench of the ordered array list core. A directed opening covers the
// empty list, inserts at both ends and in the middle, out-of-range positions,
// duplicate values and value extremes. Random traffic then fills the list to
// capacity, hammers the full list, drains it to empty and finishes with mixed
// traffic, with random gaps on the request side and random stalls on the
// response side. The checker module predicts and compares every response.
// ----------------------------------------------------------------------------
module tb_ordered_array_list_core;
    import oal_pkg::*;

    localparam int unsigned CAPACITY     = 128;
    localparam int          RANDOM_ITEMS = 450;
    localparam int          CYCLE_LIMIT  = 400_000;
    localparam int          DRAIN_CYCLES = CAPACITY + 16;
    localparam int          POS_MAX      = (1 << POS_W) - 1;
    localparam int          MAX_IDLE     = 14;

    typedef enum int {
        PH_GROW,
        PH_FULL,
        PH_SHRINK,
        PH_MIXED
    } phase_t;

    logic clk;
    logic rst_n;

    int   mismatches;
    int   pending;
    int   pred_len;
    int   responses;
    int   peak_len;
    int   full_rejects;
    int   find_misses;
    int   cycle_count;
    bit   quiet_src;
    bit   quiet_sink;

    oal_in_if  req_ch ();
    oal_out_if rsp_ch ();

    ordered_array_list_core #(
        .CAPACITY      (CAPACITY),
        .ELEMENT_WIDTH (VALUE_W)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    oal_list_checker #(
        .CAPACITY (CAPACITY)
    ) checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req_ch),
        .rsp          (rsp_ch),
        .mismatches   (mismatches),
        .pending      (pending),
        .pred_len     (pred_len),
        .responses    (responses),
        .peak_len     (peak_len),
        .full_rejects (full_rejects),
        .find_misses  (find_misses)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles with %0d responses still due", cycle_count, pending);
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin : sink_side
        int hold;
        int beats;
        rsp_ch.ready = 1'b0;
        quiet_sink   = 1'b0;
        beats        = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (beats % 40 == 0)
                quiet_sink = ($urandom_range(0, 3) == 0);
            hold = quiet_sink ? 0 : $urandom_range(0, MAX_IDLE);
            if (hold != 0)
            begin
                @(negedge clk);
                rsp_ch.ready <= 1'b0;
                repeat (hold - 1) @(negedge clk);
            end
            @(negedge clk);
            rsp_ch.ready <= 1'b1;
            do @(posedge clk); while (rsp_ch.valid !== 1'b1);
            beats++;
        end
    end

    // leaves the caller at a falling edge, ready to drive the next beat
    task automatic wait_gap();
        int gap;
        gap = quiet_src ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap != 0)
        begin
            @(negedge clk);
            req_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
    endtask

    task automatic put_beat(mode_t m, logic signed [VALUE_W-1:0] v, logic [POS_W-1:0] p);
        req_ch.valid      <= 1'b1;
        req_ch.mode       <= m;
        req_ch.item_value <= v;
        req_ch.position   <= p;
        do @(posedge clk); while (req_ch.ready !== 1'b1);
    endtask

    task automatic send_op(mode_t m, logic signed [VALUE_W-1:0] v, logic [POS_W-1:0] p);
        wait_gap();
        put_beat(m, v, p);
    endtask

    // a small pool of values makes duplicates and find hits common
    function automatic logic signed [VALUE_W-1:0] pick_value(int pool_pct);
        if ($urandom_range(0, 99) >= pool_pct)
            return $urandom;
        case ($urandom_range(0, 11))
            0:       return 32'sh0000_0000;
            1:       return -32'sd1;
            2:       return 32'sh0000_0001;
            3:       return 32'sh8000_0000;
            4:       return 32'sh7FFF_FFFF;
            5:       return 32'sh5555_5555;
            6:       return 32'shAAAA_AAAA;
            7:       return 32'sd7;
            8:       return -32'sd7;
            9:       return 32'sh0001_0000;
            10:      return 32'sd42;
            default: return 32'shDEAD_BEEF;
        endcase
    endfunction

    function automatic logic [POS_W-1:0] pick_pos(int span);
        int r;
        r = $urandom_range(0, 15);
        if (span == 0 || r < 2)
            return POS_W'($urandom_range(0, POS_MAX));
        if (r < 4)
            return POS_W'(span - 1);
        if (r < 6)
            return '0;
        return POS_W'($urandom_range(0, span - 1));
    endfunction

    task automatic pick_item(phase_t ph, output mode_t m, output logic signed [VALUE_W-1:0] v,
                             output logic [POS_W-1:0] p);
        int ins_w;
        int del_w;
        int find_w;
        int r;
        case (ph)
            PH_GROW:   begin ins_w = 80; del_w = 5;  find_w = 8;  end
            PH_FULL:   begin ins_w = 50; del_w = 0;  find_w = 20; end
            PH_SHRINK: begin ins_w = 5;  del_w = 80; find_w = 8;  end
            default:   begin ins_w = 25; del_w = 25; find_w = 25; end
        endcase
        r = $urandom_range(0, 99);
        if (r < ins_w)
        begin
            m = MODE_INSERT;
            v = pick_value(50);
            p = (pred_len >= CAPACITY) ? POS_W'($urandom_range(0, POS_MAX))
                                       : pick_pos(pred_len + 1);
        end
        else if (r < ins_w + del_w)
        begin
            m = MODE_DELETE;
            v = $urandom;
            p = pick_pos(pred_len);
        end
        else if (r < ins_w + del_w + find_w)
        begin
            m = MODE_FIND;
            v = pick_value(70);
            p = POS_W'($urandom_range(0, POS_MAX));
        end
        else
        begin
            m = MODE_READ;
            v = $urandom;
            p = pick_pos(pred_len);
        end
    endtask

    initial
    begin : source_side
        phase_t                     phase;
        int                         full_left;
        mode_t                      m;
        logic signed [VALUE_W-1:0]  v;
        logic [POS_W-1:0]           p;

        rst_n             = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.mode       = MODE_INSERT;
        req_ch.item_value = '0;
        req_ch.position   = '0;
        quiet_src         = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_op(MODE_READ,   32'sd0,          7'd0);
        send_op(MODE_DELETE, 32'sd0,          7'd0);
        send_op(MODE_FIND,   32'sd0,          7'd0);
        send_op(MODE_INSERT, 32'sd5,          7'd1);
        send_op(MODE_INSERT, 32'sh7FFF_FFFF,  7'd127);
        send_op(MODE_INSERT, 32'sh7FFF_FFFF,  7'd0);
        send_op(MODE_INSERT, 32'sh8000_0000,  7'd0);
        send_op(MODE_INSERT, -32'sd1,         7'd2);
        send_op(MODE_INSERT, 32'sd0,          7'd1);
        send_op(MODE_INSERT, 32'sh5555_5555,  7'd4);
        send_op(MODE_INSERT, 32'shAAAA_AAAA,  7'd2);
        send_op(MODE_INSERT, 32'sd7,          7'd7);
        send_op(MODE_FIND,   32'sh7FFF_FFFF,  7'd0);
        send_op(MODE_FIND,   32'sh8000_0000,  7'd127);
        send_op(MODE_FIND,   32'sh1234_5678,  7'd0);
        send_op(MODE_INSERT, -32'sd1,         7'd0);
        send_op(MODE_FIND,   -32'sd1,         7'd0);
        send_op(MODE_READ,   32'sd0,          7'd0);
        send_op(MODE_READ,   32'sd0,          7'd6);
        send_op(MODE_READ,   32'sd0,          7'd7);
        send_op(MODE_DELETE, 32'sd0,          7'd7);
        send_op(MODE_DELETE, 32'sd0,          7'd6);
        send_op(MODE_DELETE, 32'sd0,          7'd0);
        send_op(MODE_DELETE, 32'sd0,          7'd2);
        send_op(MODE_READ,   32'sd0,          7'd2);

        phase     = PH_GROW;
        full_left = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 32 == 0)
                quiet_src = ($urandom_range(0, 3) == 0);
            wait_gap();
            if (phase == PH_GROW && pred_len >= CAPACITY)
            begin
                phase     = PH_FULL;
                full_left = 12;
            end
            else if (phase == PH_FULL && full_left == 0)
            begin
                // hold off until every response is back
                req_ch.valid <= 1'b0;
                do @(negedge clk); while (pending != 0);
                phase = PH_SHRINK;
            end
            else if (phase == PH_SHRINK && pred_len == 0)
            begin
                phase = PH_MIXED;
            end
            if (phase == PH_FULL)
                full_left--;
            pick_item(phase, m, v, p);
            put_beat(m, v, p);
        end

        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Covered %0d responses; list length peaked at %0d of %0d entries.",
                 responses, peak_len, CAPACITY);
        $display("Inserts refused on a full list: %0d, finds with no match: %0d.",
                 full_rejects, find_misses);
        if (mismatches == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/oal_pkg.sv
hw/rtl/oal_in_if.sv
hw/rtl/oal_out_if.sv
hw/rtl/oal_cell.sv
hw/rtl/ordered_array_list_core.sv
dv/oal_list_checker.sv
dv/tb_ordered_array_list_core.sv
